FILE: design/frt_pkg.sv
`default_nettype none

package frt_pkg;

  // block sizing
  localparam int SLOTS        = 2;
  localparam int SLOT_W       = 1;
  localparam int MAX_PARTS    = 32;
  localparam int MASK_W       = 32;
  localparam int BUFFER_BYTES = 4096;
  localparam int HEADER_BYTES = 8;
  localparam int ID_BITS      = 64;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 4'd1;

  localparam logic [21:0] TIMEOUT_RESET   = 22'd60000;
  localparam logic [7:0]  MAX_CHUNK_RESET = 8'd200;

  // result status codes
  typedef enum logic [2:0] {
    ST_PARTIAL   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_BAD_HDR   = 3'd3,
    ST_NO_SLOT   = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_MISMATCH  = 3'd6,
    ST_BAD_LEN   = 3'd7
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CALC,
    FSM_HOLD
  } fsm_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic eval;
  } cmd_t;

  // one result word
  typedef struct packed {
    status_t     status;
    logic [SLOT_W-1:0] slot_index;
    logic [11:0] write_offset;
    logic [7:0]  chunk_len;
    logic [MASK_W-1:0] received_mask;
    logic [12:0] assembled_len;
    logic        done_compressed;
    logic [31:0] done_msg_id;
  } result_t;

endpackage

`default_nettype wire

FILE: design/frt_ctrl.sv
`default_nettype none

module frt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output frt_pkg::cmd_t      cmd
);
  import frt_pkg::*;

  fsm_t state;
  fsm_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.load_in = 1'b0;
    cmd.eval    = 1'b0;
    unique case (state)
      FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = FSM_CALC;
        end
      end
      FSM_CALC: begin
        cmd.eval   = 1'b1;
        state_next = FSM_HOLD;
      end
      FSM_HOLD: begin
        out_valid = 1'b1;
        // a new word may enter as the result leaves
        in_ready  = out_ready;
        if (out_ready) begin
          if (in_valid) begin
            cmd.load_in = 1'b1;
            state_next  = FSM_CALC;
          end else begin
            state_next = FSM_IDLE;
          end
        end
      end
      default: state_next = FSM_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/frt_dp.sv
`default_nettype none

module frt_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire frt_pkg::cmd_t                   cmd,
  input  wire logic                            cfg_we,
  input  wire logic [frt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [63:0]                     sender_id,
  input  wire logic [31:0]                     msg_id,
  input  wire logic [7:0]                      part_num,
  input  wire logic [7:0]                      part_total,
  input  wire logic [7:0]                      chunk_size,
  input  wire logic [8:0]                      payload_len,
  input  wire logic                            is_compressed,
  input  wire logic [31:0]                     now_ms,
  output frt_pkg::result_t                     result
);
  import frt_pkg::*;

  // configuration
  logic [21:0] timeout_ms;
  logic [7:0]  max_chunk;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
      max_chunk  <= MAX_CHUNK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT:   timeout_ms <= cfg_data[21:0];
        CFG_MAX_CHUNK: max_chunk  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // captured header word
  logic [ID_BITS-1:0] r_sender;
  logic [31:0] r_msg;
  logic [7:0]  r_part;
  logic [7:0]  r_total;
  logic [7:0]  r_csize;
  logic [8:0]  r_plen;
  logic        r_comp;
  logic [31:0] r_now;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      r_sender <= sender_id[ID_BITS-1:0];
      r_msg    <= msg_id;
      r_part   <= part_num;
      r_total  <= part_total;
      r_csize  <= chunk_size;
      r_plen   <= payload_len;
      r_comp   <= is_compressed;
      r_now    <= now_ms;
    end
  end

  // slot table
  logic               slot_busy       [SLOTS];
  logic [31:0]        slot_msg        [SLOTS];
  logic [ID_BITS-1:0] slot_sender     [SLOTS];
  logic [7:0]         slot_total      [SLOTS];
  logic [5:0]         slot_count      [SLOTS];
  logic               slot_has_last   [SLOTS];
  logic [7:0]         slot_last_len   [SLOTS];
  logic [MASK_W-1:0]  slot_mask       [SLOTS];
  logic [31:0]        slot_time       [SLOTS];
  logic               slot_compressed [SLOTS];

  // header checks
  logic        short_len;
  logic        bad_hdr;
  logic [15:0] prod_total;
  logic [15:0] offset;
  logic [7:0]  part_m1;
  logic [8:0]  clen;
  logic [16:0] end_sum;
  logic        is_last;

  always_comb begin
    short_len  = r_plen < 9'(HEADER_BYTES);
    bad_hdr    = (r_msg == 32'd0) || (r_part == 8'd0) || (r_total == 8'd0) ||
                 (r_part > r_total) || (r_total > 8'(MAX_PARTS)) ||
                 (r_csize == 8'd0) || (r_csize > max_chunk);
    part_m1    = r_part - 8'd1;
    prod_total = 16'(r_total) * 16'(r_csize);
    offset     = 16'(part_m1) * 16'(r_csize);
    clen       = r_plen - 9'(HEADER_BYTES);
    end_sum    = 17'(offset) + 17'(clen);
    is_last    = (r_part == r_total);
  end

  // slot search, lowest index wins
  logic              found_hit;
  logic              found_open;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] open_idx;
  logic [31:0]       age;

  always_comb begin
    found_hit  = 1'b0;
    found_open = 1'b0;
    hit_idx    = '0;
    open_idx   = '0;
    age        = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      age = r_now - slot_time[i];
      if (slot_busy[i] && (slot_msg[i] == r_msg) && (slot_sender[i] == r_sender)) begin
        found_hit = 1'b1;
        hit_idx   = SLOT_W'(i);
      end
      if (!slot_busy[i] || (age > {10'd0, timeout_ms})) begin
        found_open = 1'b1;
        open_idx   = SLOT_W'(i);
      end
    end
  end

  // decision for the chosen slot
  logic [SLOT_W-1:0] sel;
  logic              do_open;
  logic              too_large;
  logic              proceed;
  logic              mismatch;
  logic              bad_len;
  logic              dup;
  logic              complete;
  logic              len_ok;
  logic              take_part;
  logic [7:0]        cur_total;
  logic [MASK_W-1:0] cur_mask;
  logic [5:0]        cur_count;
  logic              cur_has_last;
  logic [7:0]        cur_last_len;
  logic              cur_comp;
  logic [MASK_W-1:0] bit_sel;
  logic [MASK_W-1:0] new_mask;
  logic [5:0]        new_count;
  logic              new_has_last;
  logic [7:0]        new_last_len;
  logic [15:0]       asm_sum;
  result_t           res_next;

  always_comb begin
    sel          = found_hit ? hit_idx : open_idx;
    do_open      = !short_len && !bad_hdr && !found_hit && found_open;
    too_large    = do_open && (prod_total > 16'(BUFFER_BYTES));
    proceed      = !short_len && !bad_hdr && (found_hit || found_open) && !too_large;
    cur_total    = do_open ? r_total : slot_total[sel];
    cur_mask     = do_open ? '0 : slot_mask[sel];
    cur_count    = do_open ? 6'd0 : slot_count[sel];
    cur_has_last = do_open ? 1'b0 : slot_has_last[sel];
    cur_last_len = do_open ? 8'd0 : slot_last_len[sel];
    cur_comp     = do_open ? r_comp : slot_compressed[sel];
    mismatch     = cur_total != r_total;
    bad_len      = (end_sum > 17'(BUFFER_BYTES)) ||
                   (!is_last && (clen != 9'(r_csize))) ||
                   (is_last && ((clen == 9'd0) || (clen > 9'(r_csize))));
    bit_sel      = MASK_W'(1) << part_m1[4:0];
    dup          = (cur_mask & bit_sel) != '0;
    len_ok       = proceed && !mismatch && !bad_len;
    take_part    = len_ok && !dup;
    new_mask     = cur_mask | bit_sel;
    new_count    = cur_count + 6'd1;
    new_has_last = cur_has_last | is_last;
    new_last_len = is_last ? clen[7:0] : cur_last_len;
    complete     = !((8'(new_count) < cur_total) || !new_has_last);
    // (total - 1) * chunk_size is the full product less one chunk
    asm_sum      = prod_total - 16'(r_csize) + 16'(new_last_len);

    res_next = '0;
    if (short_len) begin
      res_next.status = ST_BAD_LEN;
    end else if (bad_hdr) begin
      res_next.status = ST_BAD_HDR;
    end else if (!found_hit && !found_open) begin
      res_next.status = ST_NO_SLOT;
    end else if (too_large) begin
      res_next.status = ST_TOO_LARGE;
    end else begin
      res_next.slot_index    = sel;
      res_next.received_mask = cur_mask;
      if (mismatch) begin
        res_next.status = ST_MISMATCH;
      end else if (bad_len) begin
        res_next.status = ST_BAD_LEN;
      end else if (dup) begin
        res_next.status = ST_DUPLICATE;
      end else begin
        res_next.write_offset  = offset[11:0];
        res_next.chunk_len     = clen[7:0];
        res_next.received_mask = new_mask;
        if (complete) begin
          res_next.status          = ST_COMPLETE;
          res_next.assembled_len   = asm_sum[12:0];
          res_next.done_compressed = cur_comp;
          res_next.done_msg_id     = r_msg;
        end else begin
          res_next.status = ST_PARTIAL;
        end
      end
    end
  end

  // slot table update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_busy[i]       <= 1'b0;
        slot_msg[i]        <= '0;
        slot_sender[i]     <= '0;
        slot_total[i]      <= '0;
        slot_count[i]      <= '0;
        slot_has_last[i]   <= 1'b0;
        slot_last_len[i]   <= '0;
        slot_mask[i]       <= '0;
        slot_time[i]       <= '0;
        slot_compressed[i] <= 1'b0;
      end
    end else if (cmd.eval) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (SLOT_W'(i) == sel) begin
          if (do_open) begin
            slot_msg[i]        <= r_msg;
            slot_sender[i]     <= r_sender;
            slot_total[i]      <= r_total;
            slot_compressed[i] <= r_comp;
          end
          // new part recorded, else a fresh slot starts empty
          if (take_part) begin
            slot_mask[i]     <= new_mask;
            slot_count[i]    <= new_count;
            slot_has_last[i] <= new_has_last;
            slot_last_len[i] <= new_last_len;
            slot_busy[i]     <= !complete;
          end else if (do_open) begin
            slot_count[i]    <= '0;
            slot_has_last[i] <= 1'b0;
            slot_last_len[i] <= '0;
            slot_mask[i]     <= '0;
            slot_busy[i]     <= !too_large;
          end
          if (len_ok) begin
            slot_time[i] <= r_now;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/fragment_reassembly_tracker.sv
// Channel   Handshake                 Payload
// header    in_valid / in_ready       sender_id msg_id part_num part_total chunk_size
//                                     payload_len is_compressed now_ms
// result    out_valid / out_ready     status slot_index write_offset chunk_len
//                                     received_mask assembled_len done_compressed done_msg_id
// config    cfg_we (no wait)          cfg_index cfg_data
//
// Each header word is first captured, then goes through the slot search,
// checks and slot update in the single evaluate step of the controller.
// The result waits in an output register; a new word is taken in the cycle the
// result leaves, so no new word is taken while a result is still held.
// A stalled output holds the block. Synchronous reset clears all slots at once.
`default_nettype none

module fragment_reassembly_tracker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [63:0]                     sender_id,
  input  wire logic [31:0]                     msg_id,
  input  wire logic [7:0]                      part_num,
  input  wire logic [7:0]                      part_total,
  input  wire logic [7:0]                      chunk_size,
  input  wire logic [8:0]                      payload_len,
  input  wire logic                            is_compressed,
  input  wire logic [31:0]                     now_ms,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           status,
  output logic [0:0]                           slot_index,
  output logic [11:0]                          write_offset,
  output logic [7:0]                           chunk_len,
  output logic [31:0]                          received_mask,
  output logic [12:0]                          assembled_len,
  output logic                                 done_compressed,
  output logic [31:0]                          done_msg_id,
  input  wire logic                            cfg_we,
  input  wire logic [frt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [frt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import frt_pkg::*;

  cmd_t    cmd;
  result_t result;

  frt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  frt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sender_id     (sender_id),
    .msg_id        (msg_id),
    .part_num      (part_num),
    .part_total    (part_total),
    .chunk_size    (chunk_size),
    .payload_len   (payload_len),
    .is_compressed (is_compressed),
    .now_ms        (now_ms),
    .result        (result)
  );

  // unpack result word
  assign status          = result.status;
  assign slot_index      = result.slot_index;
  assign write_offset    = result.write_offset;
  assign chunk_len       = result.chunk_len;
  assign received_mask   = result.received_mask;
  assign assembled_len   = result.assembled_len;
  assign done_compressed = result.done_compressed;
  assign done_msg_id     = result.done_msg_id;

  // a held result is never overwritten by a new word
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> out_ready)
    else $error("input taken while result stalled");

  // an accepted word yields its result after the evaluate cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (!out_valid ##1 out_valid))
    else $error("result not presented two cycles after accept");

  // completion always carries a nonzero message id
  a_done_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_COMPLETE)) |-> (done_msg_id != 32'd0))
    else $error("complete without message id");

  // done fields stay zero unless complete
  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_COMPLETE)) |->
      ((assembled_len == 13'd0) && (done_msg_id == 32'd0) && !done_compressed))
    else $error("done fields set without completion");

endmodule

`default_nettype wire
